// ===== design/teq_pkg.sv =====
// shared types and codes of the timed event queue
package teq_pkg;

  localparam int unsigned FUNC_W      = 2;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned TIME_W      = 64;
  localparam int unsigned IN_TAG_W    = 16;
  localparam int unsigned OUT_TAG_W   = 16;
  localparam int unsigned COUNT_OUT_W = 5;

  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_POP    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_PURGE  = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  localparam logic KIND_TX    = 1'b0;
  localparam logic KIND_SCHED = 1'b1;

  typedef struct packed {
    logic [TIME_W-1:0] ev_time;
    logic              kind;
    logic [TIME_W-1:0] send_time;
  } entry_t;

  typedef struct packed {
    logic ins;
    logic pop;
    logic purge;
  } cell_ctrl_t;

endpackage

// ===== design/teq_cell.sv =====
// one slot of the sorted event chain
module teq_cell #(
  parameter int unsigned TAG_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  teq_pkg::cell_ctrl_t                ctrl_i,
  input  teq_pkg::entry_t                    new_ent_i,
  input  logic [TAG_BITS-1:0]                new_tag_i,
  input  logic [teq_pkg::TIME_W-1:0]         bound_i,
  input  teq_pkg::entry_t                    prev_ent_i,
  input  logic [TAG_BITS-1:0]                prev_tag_i,
  input  logic                               prev_valid_i,
  input  logic                               prev_stay_i,
  input  teq_pkg::entry_t                    next_ent_i,
  input  logic [TAG_BITS-1:0]                next_tag_i,
  input  logic                               next_valid_i,
  input  logic                               hole_i,
  output teq_pkg::entry_t                    ent_o,
  output logic [TAG_BITS-1:0]                tag_o,
  output logic                               valid_o,
  output logic                               stay_o,
  output logic                               hole_o
);

  teq_pkg::entry_t     ent_q, ent_d;
  logic [TAG_BITS-1:0] tag_q, tag_d;
  logic                valid_q, valid_d;
  logic                stay;
  logic                drop;

  // entry keeps its place on insert when it sorts ahead of the new one
  assign stay = valid_q && ((new_ent_i.kind == teq_pkg::KIND_SCHED) ?
                            (ent_q.ev_time <= new_ent_i.ev_time) :
                            (ent_q.ev_time < new_ent_i.ev_time));
  assign drop = valid_q && (ent_q.kind == teq_pkg::KIND_TX) &&
                (ent_q.send_time > bound_i);
  assign hole_o = hole_i || drop;

  always_comb begin
    ent_d   = ent_q;
    tag_d   = tag_q;
    valid_d = valid_q;
    if (ctrl_i.ins) begin
      if (!stay) begin
        if (prev_stay_i) begin
          ent_d   = new_ent_i;
          tag_d   = new_tag_i;
          valid_d = 1'b1;
        end else begin
          ent_d   = prev_ent_i;
          tag_d   = prev_tag_i;
          valid_d = prev_valid_i;
        end
      end
    end else if (ctrl_i.pop || (ctrl_i.purge && hole_o)) begin
      ent_d   = next_ent_i;
      tag_d   = next_tag_i;
      valid_d = next_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
    tag_q <= tag_d;
  end

  assign ent_o   = ent_q;
  assign tag_o   = tag_q;
  assign valid_o = valid_q;
  assign stay_o  = stay;

endmodule

// ===== design/timed_event_queue_unit.sv =====
// top level of the timed event queue: control, result register and cell chain
//
// Pending events sit in a chain of QUEUE_DEPTH cells kept sorted by due time,
// the head in the first cell. Insert, pop and no-op requests complete in the
// cycle they are accepted: every cell compares its time with the new one and
// either holds, takes the new entry or takes its left neighbor's entry, and a
// pop shifts the whole chain left by one. A purge holds the unit in its purge
// state after the request is accepted: each cycle removes the first entry that
// fails the bound, shifting all cells behind it left, and once nothing is left
// to drop it loads the result and returns to idle. The result sits in an
// output register, so a new request is taken in the same cycle the previous
// result is taken.
module timed_event_queue_unit #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned TAG_BITS    = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [teq_pkg::FUNC_W-1:0]          func_i,
  input  logic                                kind_i,
  input  logic [teq_pkg::TIME_W-1:0]          event_time_i,
  input  logic [teq_pkg::TIME_W-1:0]          send_time_i,
  input  logic [teq_pkg::IN_TAG_W-1:0]        event_tag_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [teq_pkg::STATUS_W-1:0]        status_o,
  output logic                                entry_valid_o,
  output logic [teq_pkg::TIME_W-1:0]          out_time_o,
  output logic                                out_kind_o,
  output logic [teq_pkg::TIME_W-1:0]          out_send_time_o,
  output logic [teq_pkg::OUT_TAG_W-1:0]       out_tag_o,
  output logic [teq_pkg::COUNT_OUT_W-1:0]     entry_count_o
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(QUEUE_DEPTH);
  localparam logic [CntW-1:0] CntOne = CntW'(1);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_PURGE = 1'b1;

  logic                state_q, state_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [teq_pkg::TIME_W-1:0] bound_q, bound_d;

  logic                out_valid_q, out_valid_d;
  logic                out_load;
  logic [teq_pkg::STATUS_W-1:0] status_q, status_d;
  logic                ev_q, ev_d;
  teq_pkg::entry_t     rep_q, rep_d;
  logic [TAG_BITS-1:0] rep_tag_q, rep_tag_d;
  logic [CntW-1:0]     rep_cnt_q, rep_cnt_d;

  logic                in_fire;
  logic                out_free;
  logic                ins_go;
  logic                pop_go;
  logic                any_drop;
  teq_pkg::cell_ctrl_t ctrl;
  teq_pkg::entry_t     new_ent;
  logic [TAG_BITS-1:0] new_tag;

  teq_pkg::entry_t     ent_w      [QUEUE_DEPTH];
  logic [TAG_BITS-1:0] tag_w      [QUEUE_DEPTH];
  logic                valid_w    [QUEUE_DEPTH];
  logic                stay_w     [QUEUE_DEPTH];
  logic                hole_w     [QUEUE_DEPTH];
  teq_pkg::entry_t     prev_ent_w [QUEUE_DEPTH];
  logic [TAG_BITS-1:0] prev_tag_w [QUEUE_DEPTH];
  logic                prev_vld_w [QUEUE_DEPTH];
  logic                prev_sty_w [QUEUE_DEPTH];
  logic                hole_in_w  [QUEUE_DEPTH];
  teq_pkg::entry_t     next_ent_w [QUEUE_DEPTH];
  logic [TAG_BITS-1:0] next_tag_w [QUEUE_DEPTH];
  logic                next_vld_w [QUEUE_DEPTH];

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  assign ins_go = in_fire && (func_i == teq_pkg::FUNC_INSERT) && (count_q != CntMax);
  assign pop_go = in_fire && (func_i == teq_pkg::FUNC_POP) && (count_q != '0);

  assign new_ent.ev_time   = event_time_i;
  assign new_ent.kind      = kind_i;
  assign new_ent.send_time = send_time_i;
  assign new_tag           = TAG_BITS'(event_tag_i);

  assign ctrl.ins   = ins_go;
  assign ctrl.pop   = pop_go;
  assign ctrl.purge = (state_q == ST_PURGE);

  assign any_drop = hole_w[QUEUE_DEPTH-1];

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign prev_ent_w[i] = '0;
      assign prev_tag_w[i] = '0;
      assign prev_vld_w[i] = 1'b0;
      assign prev_sty_w[i] = 1'b1;
      assign hole_in_w[i]  = 1'b0;
    end else begin : g_mid
      assign prev_ent_w[i] = ent_w[i-1];
      assign prev_tag_w[i] = tag_w[i-1];
      assign prev_vld_w[i] = valid_w[i-1];
      assign prev_sty_w[i] = stay_w[i-1];
      assign hole_in_w[i]  = hole_w[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign next_ent_w[i] = '0;
      assign next_tag_w[i] = '0;
      assign next_vld_w[i] = 1'b0;
    end else begin : g_inner
      assign next_ent_w[i] = ent_w[i+1];
      assign next_tag_w[i] = tag_w[i+1];
      assign next_vld_w[i] = valid_w[i+1];
    end

    teq_cell #(
      .TAG_BITS (TAG_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .new_ent_i    (new_ent),
      .new_tag_i    (new_tag),
      .bound_i      (bound_q),
      .prev_ent_i   (prev_ent_w[i]),
      .prev_tag_i   (prev_tag_w[i]),
      .prev_valid_i (prev_vld_w[i]),
      .prev_stay_i  (prev_sty_w[i]),
      .next_ent_i   (next_ent_w[i]),
      .next_tag_i   (next_tag_w[i]),
      .next_valid_i (next_vld_w[i]),
      .hole_i       (hole_in_w[i]),
      .ent_o        (ent_w[i]),
      .tag_o        (tag_w[i]),
      .valid_o      (valid_w[i]),
      .stay_o       (stay_w[i]),
      .hole_o       (hole_w[i])
    );
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    bound_d   = bound_q;
    out_load  = 1'b0;
    status_d  = teq_pkg::STATUS_DONE;
    ev_d      = valid_w[0];
    rep_d     = ent_w[0];
    rep_tag_d = tag_w[0];
    rep_cnt_d = count_q;

    if (in_fire) begin
      case (func_i)
        teq_pkg::FUNC_INSERT: begin
          out_load = 1'b1;
          if (count_q == CntMax) begin
            status_d = teq_pkg::STATUS_FULL;
          end else begin
            count_d   = count_q + CntOne;
            rep_cnt_d = count_q + CntOne;
            ev_d      = 1'b1;
            if (!stay_w[0]) begin
              rep_d     = new_ent;
              rep_tag_d = new_tag;
            end
          end
        end
        teq_pkg::FUNC_POP: begin
          out_load = 1'b1;
          if (count_q == '0) begin
            status_d = teq_pkg::STATUS_EMPTY;
            ev_d     = 1'b0;
          end else begin
            count_d   = count_q - CntOne;
            rep_cnt_d = count_q - CntOne;
          end
        end
        teq_pkg::FUNC_PURGE: begin
          bound_d = event_time_i;
          state_d = ST_PURGE;
        end
        default: begin
          out_load = 1'b1;
        end
      endcase
    end else if (state_q == ST_PURGE) begin
      if (any_drop) begin
        count_d = count_q - CntOne;
      end else if (out_free) begin
        out_load = 1'b1;
        state_d  = ST_IDLE;
      end
    end

    if (!ev_d) begin
      rep_d     = '0;
      rep_tag_d = '0;
    end

    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bound_q <= bound_d;
    if (out_load) begin
      status_q  <= status_d;
      ev_q      <= ev_d;
      rep_q     <= rep_d;
      rep_tag_q <= rep_tag_d;
      rep_cnt_q <= rep_cnt_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign entry_valid_o   = ev_q;
  assign out_time_o      = rep_q.ev_time;
  assign out_kind_o      = rep_q.kind;
  assign out_send_time_o = rep_q.send_time;
  assign out_tag_o       = teq_pkg::OUT_TAG_W'(rep_tag_q);
  assign entry_count_o   = teq_pkg::COUNT_OUT_W'(rep_cnt_q);

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntMax)
    else $error("entry count above queue depth");

  a_head_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_w[0] == (count_q != '0))
    else $error("head cell valid disagrees with entry count");

  a_purge_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PURGE) |-> !in_ready_o)
    else $error("request taken during purge");

  a_pop_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_go |=> (count_q == $past(count_q) - CntOne))
    else $error("pop did not remove one entry");
`endif

endmodule
